### rtl/sait_pkg.sv
// Package for the separating-axis interval test block.
// Holds the item kind codes, the control struct passed between stages and width helpers.
// No dependencies.
package sait_pkg;

    localparam int DEFAULT_COORD_WIDTH = 24;
    localparam int KIND_W              = 3;
    localparam int MAX_PROJ_W          = 64;

    // Item kind codes; codes 5 to 7 carry no meaning and are ignored.
    typedef enum logic [KIND_W-1:0] {
        KIND_AXIS     = 3'd0,
        KIND_CENTRE_A = 3'd1,
        KIND_CENTRE_B = 3'd2,
        KIND_VERTEX_A = 3'd3,
        KIND_VERTEX_B = 3'd4
    } item_kind_t;

    // Control bits that travel with a vector through the pipeline.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
    } sait_ctl_t;

    // Width of a projection: an exact dot product of three components,
    // wrapped to 64 bits when it would be wider.
    function automatic int proj_width(int coord_width);
        int w;
        w = 2 * coord_width + 2;
        return (w > MAX_PROJ_W) ? MAX_PROJ_W : w;
    endfunction

endpackage

### rtl/sait_if.sv
// Channel interfaces of the separating-axis interval test block.
// Depends on sait_pkg for the kind width and the default coordinate width.
interface sait_in_if #(
    parameter int COORD_WIDTH = sait_pkg::DEFAULT_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [sait_pkg::KIND_W-1:0]   item_kind;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          last_item;

    modport source (
        output valid, item_kind, coord_x, coord_y, coord_z, last_item,
        input  ready
    );
    modport sink (
        input  valid, item_kind, coord_x, coord_y, coord_z, last_item,
        output ready
    );
endinterface

interface sait_out_if;
    logic valid;
    logic ready;
    logic separated;
    logic empty_set_flag;

    modport source (
        output valid, separated, empty_set_flag,
        input  ready
    );
    modport sink (
        input  valid, separated, empty_set_flag,
        output ready
    );
endinterface

### rtl/sait_project.sv
// Projection pipeline: input register, axis register, product register, projection register.
// Depends on sait_pkg and sait_in_if.
module sait_project #(
    parameter int COORD_WIDTH = sait_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sait_in_if.sink              items,
    output logic                 proj_valid,
    input  logic                 proj_ready,
    output sait_pkg::sait_ctl_t  proj_ctl,
    output logic signed [sait_pkg::proj_width(COORD_WIDTH)-1:0] proj
);

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int PROJ_W = sait_pkg::proj_width(COORD_WIDTH);

    // Input stage.
    logic                          in_valid_reg;
    sait_pkg::sait_ctl_t           in_ctl_reg;
    logic signed [COORD_WIDTH-1:0] in_x_reg;
    logic signed [COORD_WIDTH-1:0] in_y_reg;
    logic signed [COORD_WIDTH-1:0] in_z_reg;

    // Held axis.
    logic signed [COORD_WIDTH-1:0] axis_x_reg;
    logic signed [COORD_WIDTH-1:0] axis_y_reg;
    logic signed [COORD_WIDTH-1:0] axis_z_reg;

    // Product stage.
    logic                     prod_valid_reg;
    sait_pkg::sait_ctl_t      prod_ctl_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_z_next;

    // Projection stage.
    logic                     proj_valid_reg;
    sait_pkg::sait_ctl_t      proj_ctl_reg;
    logic signed [PROJ_W-1:0] proj_reg;
    logic signed [SUM_W-1:0]  sum_next;

    logic proj_stage_ready;
    logic prod_stage_ready;
    logic in_stage_ready;
    logic in_moves;
    logic in_take;

    assign proj_stage_ready = !proj_valid_reg || proj_ready;
    assign prod_stage_ready = !prod_valid_reg || proj_stage_ready;
    assign in_stage_ready   = !in_valid_reg || prod_stage_ready;
    assign in_moves         = in_valid_reg && prod_stage_ready;
    assign in_take          = items.valid && in_stage_ready;
    assign items.ready      = in_stage_ready;

    assign prod_x_next = in_x_reg * axis_x_reg;
    assign prod_y_next = in_y_reg * axis_y_reg;
    assign prod_z_next = in_z_reg * axis_z_reg;

    assign sum_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg);

    assign proj_valid = proj_valid_reg;
    assign proj_ctl   = proj_ctl_reg;
    assign proj       = proj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            proj_valid_reg <= 1'b0;
            axis_x_reg     <= '0;
            axis_y_reg     <= '0;
            axis_z_reg     <= '0;
        end
        else
        begin
            if (in_stage_ready)
            begin
                in_valid_reg <= items.valid;
            end
            if (prod_stage_ready)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (proj_stage_ready)
            begin
                proj_valid_reg <= prod_valid_reg;
            end
            // The axis changes as the axis vector leaves the input stage, so
            // every later vector multiplies against it.
            if (in_moves && in_ctl_reg.kind == sait_pkg::KIND_AXIS)
            begin
                axis_x_reg <= in_x_reg;
                axis_y_reg <= in_y_reg;
                axis_z_reg <= in_z_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ctl_reg.kind <= items.item_kind;
            in_ctl_reg.last <= items.last_item;
            in_x_reg        <= items.coord_x;
            in_y_reg        <= items.coord_y;
            in_z_reg        <= items.coord_z;
        end
        if (prod_stage_ready)
        begin
            prod_ctl_reg <= in_ctl_reg;
            prod_x_reg   <= prod_x_next;
            prod_y_reg   <= prod_y_next;
            prod_z_reg   <= prod_z_next;
        end
        if (proj_stage_ready)
        begin
            proj_ctl_reg <= prod_ctl_reg;
            proj_reg     <= sum_next[PROJ_W-1:0];
        end
    end

endmodule

### rtl/sait_interval.sv
// Interval tracker: centre projections, running min and max of both vertex sets,
// pending result stage and result register. Depends on sait_pkg and sait_out_if.
module sait_interval #(
    parameter int COORD_WIDTH = sait_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 proj_valid,
    output logic                 proj_ready,
    input  sait_pkg::sait_ctl_t  proj_ctl,
    input  logic signed [sait_pkg::proj_width(COORD_WIDTH)-1:0] proj,
    sait_out_if.source           results
);

    localparam int PROJ_W = sait_pkg::proj_width(COORD_WIDTH);

    logic signed [PROJ_W-1:0] centre_a_reg;
    logic signed [PROJ_W-1:0] centre_b_reg;
    logic signed [PROJ_W-1:0] a_min_reg;
    logic signed [PROJ_W-1:0] a_max_reg;
    logic signed [PROJ_W-1:0] b_min_reg;
    logic signed [PROJ_W-1:0] b_max_reg;
    logic                     seen_a_reg;
    logic                     seen_b_reg;

    logic signed [PROJ_W-1:0] centre_a_next;
    logic signed [PROJ_W-1:0] centre_b_next;
    logic signed [PROJ_W-1:0] a_min_next;
    logic signed [PROJ_W-1:0] a_max_next;
    logic signed [PROJ_W-1:0] b_min_next;
    logic signed [PROJ_W-1:0] b_max_next;
    logic                     seen_a_next;
    logic                     seen_b_next;
    logic                     seen_a_upd;
    logic                     seen_b_upd;

    logic pend_valid_reg;
    logic pend_empty_reg;
    logic out_valid_reg;
    logic separated_reg;
    logic empty_reg;

    logic out_free;
    logic pend_ready;
    logic move;
    logic close_test;
    logic separated_next;

    assign out_free   = !out_valid_reg || results.ready;
    assign pend_ready = !pend_valid_reg || out_free;
    assign proj_ready = pend_ready;
    assign move       = proj_valid && pend_ready;
    assign close_test = move && proj_ctl.last;

    always_comb
    begin
        centre_a_next = centre_a_reg;
        centre_b_next = centre_b_reg;
        a_min_next    = a_min_reg;
        a_max_next    = a_max_reg;
        b_min_next    = b_min_reg;
        b_max_next    = b_max_reg;
        seen_a_upd    = seen_a_reg;
        seen_b_upd    = seen_b_reg;
        if (move)
        begin
            unique case (proj_ctl.kind)
                sait_pkg::KIND_CENTRE_A:
                begin
                    centre_a_next = proj;
                end
                sait_pkg::KIND_CENTRE_B:
                begin
                    centre_b_next = proj;
                end
                sait_pkg::KIND_VERTEX_A:
                begin
                    seen_a_upd = 1'b1;
                    if (!seen_a_reg || proj < a_min_reg)
                    begin
                        a_min_next = proj;
                    end
                    if (!seen_a_reg || proj > a_max_reg)
                    begin
                        a_max_next = proj;
                    end
                end
                sait_pkg::KIND_VERTEX_B:
                begin
                    seen_b_upd = 1'b1;
                    if (!seen_b_reg || proj < b_min_reg)
                    begin
                        b_min_next = proj;
                    end
                    if (!seen_b_reg || proj > b_max_reg)
                    begin
                        b_max_next = proj;
                    end
                end
                default:
                begin
                    // The axis is held upstream; undefined kinds are dropped.
                end
            endcase
        end
        seen_a_next = seen_a_upd && !close_test;
        seen_b_next = seen_b_upd && !close_test;
    end

    // The pending result reads the stored intervals, which stay frozen until it
    // has moved into the result register.
    always_comb
    begin
        if (centre_a_reg < centre_b_reg)
        begin
            separated_next = !pend_empty_reg && (a_max_reg < b_min_reg);
        end
        else
        begin
            separated_next = !pend_empty_reg && (a_min_reg > b_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_a_reg   <= '0;
            centre_b_reg   <= '0;
            a_min_reg      <= '0;
            a_max_reg      <= '0;
            b_min_reg      <= '0;
            b_max_reg      <= '0;
            seen_a_reg     <= 1'b0;
            seen_b_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            centre_a_reg <= centre_a_next;
            centre_b_reg <= centre_b_next;
            a_min_reg    <= a_min_next;
            a_max_reg    <= a_max_next;
            b_min_reg    <= b_min_next;
            b_max_reg    <= b_max_next;
            seen_a_reg   <= seen_a_next;
            seen_b_reg   <= seen_b_next;
            if (pend_ready)
            begin
                pend_valid_reg <= close_test;
            end
            if (out_free)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_ready)
        begin
            pend_empty_reg <= !(seen_a_upd && seen_b_upd);
        end
        if (out_free)
        begin
            separated_reg <= separated_next;
            empty_reg     <= pend_empty_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.separated      = separated_reg;
    assign results.empty_set_flag = empty_reg;

endmodule

### rtl/separating_axis_interval_test.sv
// Top level of the separating-axis interval test block.
// Depends on sait_pkg, sait_if, sait_project and sait_interval.
//
// The block takes one vector transaction per clock and reports, once per test,
// whether two convex sets are separated along a chosen axis. A test starts with
// an axis vector; each later centre or vertex vector is projected onto that axis
// by an exact integer dot product (wrapped to 64 bits if COORD_WIDTH >= 32).
// The block keeps both centre projections and the running minimum and maximum
// of each vertex set. The transaction with last_item set closes the test and
// yields one result transaction: when centre A projects strictly below centre B,
// separated is A's maximum below B's minimum, otherwise A's minimum above B's
// maximum. If either vertex set saw no vertex, empty_set_flag is set and
// separated is 0. Item kinds 5 to 7 carry no vector but a set last_item still
// closes the test. A centre that is not sent keeps its value from an earlier
// test (zero after reset). Throughput is one transaction per cycle: the
// pipeline is an input register, a register of the three coordinate products,
// a register of their sum, the interval update together with a pending result
// stage, and the result register. Stalls on the result side only hold the
// pipeline once both the result register and the pending stage are full;
// until then new transactions keep flowing in.
module separating_axis_interval_test #(
    parameter int COORD_WIDTH = sait_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sait_in_if.sink    items,
    sait_out_if.source results
);

    localparam int PROJ_W = sait_pkg::proj_width(COORD_WIDTH);

    logic                     proj_valid;
    logic                     proj_ready;
    sait_pkg::sait_ctl_t      proj_ctl;
    logic signed [PROJ_W-1:0] proj;

    // Input register, axis hold, coordinate products and their sum.
    sait_project #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .proj_valid(proj_valid),
        .proj_ready(proj_ready),
        .proj_ctl  (proj_ctl),
        .proj      (proj)
    );

    // Interval bookkeeping and the result handshake.
    sait_interval #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_interval (
        .clk       (clk),
        .rst_n     (rst_n),
        .proj_valid(proj_valid),
        .proj_ready(proj_ready),
        .proj_ctl  (proj_ctl),
        .proj      (proj),
        .results   (results)
    );

endmodule

### rtl/sait_checker.sv
// Port-level checks for the separating-axis interval test block, and their binding.
// Depends on separating_axis_interval_test and its channel interfaces.
module sait_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic separated,
    input logic empty_set_flag
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result transaction keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(separated) && $stable(empty_set_flag))
        else $error("result payload changed while stalled");

    // An empty vertex set never reports separation.
    a_empty_not_sep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_set_flag |-> !separated)
        else $error("separated reported with an empty vertex set");

    // With no result waiting, nothing in the pipeline can hold off the input.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled although no result is waiting");

endmodule

bind separating_axis_interval_test sait_checker u_sait_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (items.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .separated     (results.separated),
    .empty_set_flag(results.empty_set_flag)
);

### tb/tb_separating_axis_interval_test.sv
// Self-checking testbench for the separating-axis interval test block.
// Depends on sait_pkg, the sait_in_if and sait_out_if channel interfaces, and the block itself.
// It drives vector transactions, predicts every verdict and checks each result transaction.
module tb_separating_axis_interval_test;

    localparam int     CW            = sait_pkg::DEFAULT_COORD_WIDTH;
    localparam int     PW            = (2 * CW + 2 > sait_pkg::MAX_PROJ_W) ?
                                       sait_pkg::MAX_PROJ_W : 2 * CW + 2;
    localparam longint COORD_MAX     = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN     = -(longint'(1) << (CW - 1));
    localparam int     RANDOM_ITEMS  = 500;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT   = 200000;

    typedef logic [sait_pkg::KIND_W-1:0] kind_t;

    // Kind codes past the vertex of B carry no vector and are ignored by the block.
    localparam kind_t KIND_SPARE_LO = 3'd5;
    localparam kind_t KIND_SPARE_HI = 3'd7;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [PW-1:0] proj_t;

    localparam coord_t C_MAX = coord_t'(COORD_MAX);
    localparam coord_t C_MIN = coord_t'(COORD_MIN);
    localparam coord_t ONE   = coord_t'(4096);   // 1.0 in Q12.12

    // One vector transaction as the sender sees it.
    typedef struct {
        kind_t  kind;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } vec_item_t;

    // One verdict as the result channel carries it.
    typedef struct packed {
        logic separated;
        logic empty_set;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sait_in_if #(.COORD_WIDTH(CW)) vec_ch ();
    sait_out_if                    res_ch ();

    separating_axis_interval_test #(.COORD_WIDTH(CW)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (vec_ch),
        .results (res_ch)
    );

    // Clock: period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Interval predictor. It mirrors the block's architectural state: the
    // held axis, both centre projections, the running minimum and maximum
    // of each vertex set and the flags that say whether a set has a vertex.
    // ------------------------------------------------------------------
    coord_t axis_x = '0;
    coord_t axis_y = '0;
    coord_t axis_z = '0;
    proj_t  centre_a = '0;
    proj_t  centre_b = '0;
    proj_t  a_lo = '0;
    proj_t  a_hi = '0;
    proj_t  b_lo = '0;
    proj_t  b_hi = '0;
    logic   seen_a = 1'b0;
    logic   seen_b = 1'b0;

    // Verdicts predicted for closed tests whose result transaction is still due.
    verdict_t pending_verdicts[$];

    // Bookkeeping shared by the sender, the checker and the summary.
    logic   idle_on = 1'b1;
    int     vectors_sent = 0;
    int     error_count = 0;
    int     closed_tests = 0;
    int     separated_tests = 0;
    int     empty_tests = 0;
    int     stall_left = 0;
    longint cycle_count = 0;

    // Updates the predicted state for one accepted transaction and, when the
    // transaction closes a test, queues the verdict the block must report.
    function automatic void predict_interval(vec_item_t it);
        proj_t    p;
        verdict_t v;
        p = proj_t'(it.x) * proj_t'(axis_x) + proj_t'(it.y) * proj_t'(axis_y)
            + proj_t'(it.z) * proj_t'(axis_z);
        case (it.kind)
            sait_pkg::KIND_AXIS:
            begin
                axis_x = it.x;
                axis_y = it.y;
                axis_z = it.z;
            end
            sait_pkg::KIND_CENTRE_A: centre_a = p;
            sait_pkg::KIND_CENTRE_B: centre_b = p;
            sait_pkg::KIND_VERTEX_A:
            begin
                if (!seen_a)
                begin
                    a_lo   = p;
                    a_hi   = p;
                    seen_a = 1'b1;
                end
                else
                begin
                    if (p < a_lo) a_lo = p;
                    if (p > a_hi) a_hi = p;
                end
            end
            sait_pkg::KIND_VERTEX_B:
            begin
                if (!seen_b)
                begin
                    b_lo   = p;
                    b_hi   = p;
                    seen_b = 1'b1;
                end
                else
                begin
                    if (p < b_lo) b_lo = p;
                    if (p > b_hi) b_hi = p;
                end
            end
            default: ;
        endcase
        if (it.last)
        begin
            v.empty_set = !seen_a || !seen_b;
            v.separated = 1'b0;
            // The side on which A's centre falls picks which interval ends face each other.
            if (!v.empty_set)
            begin
                if (centre_a < centre_b)
                    v.separated = a_hi < b_lo;
                else
                    v.separated = a_lo > b_hi;
            end
            seen_a = 1'b0;
            seen_b = 1'b0;
            pending_verdicts.push_back(v);
        end
    endfunction

    function automatic vec_item_t vec(kind_t kind, coord_t x, coord_t y, coord_t z,
                                      logic last);
        vec_item_t it;
        it.kind = kind;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        it.last = last;
        return it;
    endfunction

    // A coordinate within spread of centre, clipped to the coordinate range.
    function automatic coord_t near(longint centre, int spread);
        longint v;
        v = centre + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("[cycle %0d] mismatch: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Sender. Presents one transaction, holding valid and the payload until
    // the block takes it, then hands it to the predictor. When idling is on,
    // a random burst of empty cycles may come first. Inputs change only by
    // nonblocking assignment at the rising edge, and ready is sampled in the
    // same step, before the block's registers update.
    // ------------------------------------------------------------------
    task automatic send_item(vec_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        vec_ch.valid     <= 1'b1;
        vec_ch.item_kind <= it.kind;
        vec_ch.coord_x   <= it.x;
        vec_ch.coord_y   <= it.y;
        vec_ch.coord_z   <= it.z;
        vec_ch.last_item <= it.last;
        do
            @(posedge clk);
        while (!vec_ch.ready);
        predict_interval(it);
        if (it.kind <= sait_pkg::KIND_VERTEX_B)
            vectors_sent++;
    endtask

    // Holds the sender off until every predicted verdict has been checked.
    task automatic wait_for_results();
        vec_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side. Each accepted result transaction is compared with the
    // oldest predicted verdict. Ready drops in random stall bursts while
    // idling is on and stays high otherwise.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result transaction arrived with no verdict pending");
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_ch.separated !== want.separated)
                    report_mismatch($sformatf("separated is %b, predicted %b",
                                              res_ch.separated, want.separated));
                if (res_ch.empty_set_flag !== want.empty_set)
                    report_mismatch($sformatf("empty_set_flag is %b, predicted %b",
                                              res_ch.empty_set_flag, want.empty_set));
                closed_tests++;
                if (want.separated) separated_tests++;
                if (want.empty_set) empty_tests++;
            end
        end
        if (!idle_on)
            res_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d verdicts pending.",
                     cycle_count, pending_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Right after reset both centres project to zero, so the tie takes the
    // branch that compares A's minimum with B's maximum.
    task automatic test_centres_at_reset();
        send_item(vec(sait_pkg::KIND_AXIS, ONE, 0, 0, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, 5, 7, 9, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, -5, -7, -9, 1'b1));
    endtask

    // Full-scale coordinates on every field, with the largest products the
    // projection has to hold exactly.
    task automatic test_extreme_values();
        send_item(vec(sait_pkg::KIND_AXIS, C_MAX, C_MIN, C_MAX, 1'b0));
        send_item(vec(sait_pkg::KIND_CENTRE_A, C_MIN, C_MAX, C_MIN, 1'b0));
        send_item(vec(sait_pkg::KIND_CENTRE_B, C_MAX, C_MIN, C_MAX, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, C_MIN, C_MAX, C_MIN, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, 0, 0, -1, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, C_MAX, C_MIN, C_MAX, 1'b1));
    endtask

    // No centre is sent: the projections held from the previous test decide.
    task automatic test_held_centres();
        send_item(vec(sait_pkg::KIND_AXIS, 0, ONE, 0, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, 0, 10, 0, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, 0, 20, 0, 1'b1));
    endtask

    // A test closed while one vertex set is empty, twice in a row so the
    // seen flags must have been cleared by the first verdict.
    task automatic test_empty_sets();
        send_item(vec(sait_pkg::KIND_AXIS, ONE, ONE, ONE, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, 1, 2, 3, 1'b1));
        send_item(vec(sait_pkg::KIND_VERTEX_B, 1, 2, 3, 1'b1));
    endtask

    // Spare kinds leave the state alone but still close a test when marked last.
    task automatic test_ignored_kinds();
        int k;
        send_item(vec(sait_pkg::KIND_VERTEX_A, 1, 1, 1, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, 2, 2, 2, 1'b0));
        for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_item(vec(kind_t'(k), any_coord(), any_coord(), any_coord(),
                          k == KIND_SPARE_HI));
        send_item(vec(kind_t'(KIND_SPARE_LO + 1), C_MIN, C_MAX, -1, 1'b1));
    endtask

    // An axis that closes the test is stored, but the verdict uses the
    // projections taken on the previous axis.
    task automatic test_axis_closes_test();
        send_item(vec(sait_pkg::KIND_VERTEX_A, -1, -1, -1, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, 1, 1, 1, 1'b0));
        send_item(vec(sait_pkg::KIND_AXIS, 0, 0, ONE, 1'b1));
    endtask

    // With a zero axis every projection is zero and nothing is ever separated.
    task automatic test_zero_axis();
        send_item(vec(sait_pkg::KIND_AXIS, 0, 0, 0, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_A, C_MAX, C_MAX, C_MAX, 1'b0));
        send_item(vec(sait_pkg::KIND_VERTEX_B, C_MIN, C_MIN, C_MIN, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Random tests. Most are well-formed: an axis, the two centres and a few
    // vertices clustered around each centre, in random order after the axis,
    // with the final transaction marked last. The cluster spread against the
    // centre distance makes separated and overlapping verdicts both common.
    // Some tests drop the axis, a centre or a whole vertex set, or carry a
    // spare kind; now and then a burst of pure noise goes in between. The
    // sender drains the block every dozen tests, and the last fifth of the
    // run goes without any idling on either side.
    // ------------------------------------------------------------------
    task automatic test_random_tests();
        vec_item_t seq[$];
        vec_item_t it;
        vec_item_t last_a;
        longint    ca[3];
        longint    cb[3];
        int        spread;
        int        n_a;
        int        n_b;
        int        first_free;
        int        pos;
        int        pick;
        int        tests_run;
        int        goal;
        int        quiet_from;
        goal       = vectors_sent + RANDOM_ITEMS;
        quiet_from = vectors_sent + RANDOM_ITEMS * 4 / 5;
        tests_run  = 0;
        while (vectors_sent < goal)
        begin
            if (vectors_sent >= quiet_from)
                idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(vec(kind_t'($urandom_range(sait_pkg::KIND_AXIS, KIND_SPARE_HI)),
                                  any_coord(), any_coord(), any_coord(),
                                  $urandom_range(0, 3) == 0));
            end
            else
            begin
                seq.delete();
                if ($urandom_range(0, 9) != 0)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        it = vec(sait_pkg::KIND_AXIS, 0, 0, 0, 1'b0);
                    else if (pick <= 2)
                        it = vec(sait_pkg::KIND_AXIS, any_coord(), any_coord(), any_coord(),
                                 1'b0);
                    else
                        it = vec(sait_pkg::KIND_AXIS, near(0, 4096), near(0, 4096),
                                 near(0, 4096), 1'b0);
                    seq.push_back(it);
                end
                first_free = seq.size();
                for (int k = 0; k < 3; k++)
                begin
                    ca[k] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                    cb[k] = ca[k] + longint'($urandom_range(0, 1 << 19)) - (1 << 18);
                end
                spread = 1 << $urandom_range(0, 17);
                n_a = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                n_b = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                // Build the body of the test; each item lands at a random place after the axis.
                for (int k = 0; k < 2 + n_a + n_b + 1; k++)
                begin
                    if (k == 0)
                    begin
                        if ($urandom_range(0, 7) == 0) continue;
                        it = vec(sait_pkg::KIND_CENTRE_A, near(ca[0], 0), near(ca[1], 0),
                                 near(ca[2], 0), 1'b0);
                    end
                    else if (k == 1)
                    begin
                        if ($urandom_range(0, 7) == 0) continue;
                        it = vec(sait_pkg::KIND_CENTRE_B, near(cb[0], 0), near(cb[1], 0),
                                 near(cb[2], 0), 1'b0);
                    end
                    else if (k < 2 + n_a)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            it = vec(sait_pkg::KIND_VERTEX_A, any_coord(), any_coord(),
                                     any_coord(), 1'b0);
                        else
                            it = vec(sait_pkg::KIND_VERTEX_A, near(ca[0], spread),
                                     near(ca[1], spread), near(ca[2], spread), 1'b0);
                        last_a = it;
                    end
                    else if (k < 2 + n_a + n_b)
                    begin
                        // Occasionally B repeats a vertex of A, so the intervals touch exactly.
                        if (n_a > 0 && $urandom_range(0, 9) == 0)
                            it = vec(sait_pkg::KIND_VERTEX_B, last_a.x, last_a.y, last_a.z,
                                     1'b0);
                        else if ($urandom_range(0, 7) == 0)
                            it = vec(sait_pkg::KIND_VERTEX_B, any_coord(), any_coord(),
                                     any_coord(), 1'b0);
                        else
                            it = vec(sait_pkg::KIND_VERTEX_B, near(cb[0], spread),
                                     near(cb[1], spread), near(cb[2], spread), 1'b0);
                    end
                    else
                    begin
                        if ($urandom_range(0, 11) != 0) continue;
                        it = vec(kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                 any_coord(), any_coord(), any_coord(), 1'b0);
                    end
                    pos = $urandom_range(first_free, seq.size());
                    if (pos == seq.size())
                        seq.push_back(it);
                    else
                        seq.insert(pos, it);
                end
                if (seq.size() == 0)
                    seq.push_back(vec(KIND_SPARE_HI, any_coord(), any_coord(), any_coord(), 1'b0));
                seq[seq.size() - 1].last = 1'b1;
                foreach (seq[i])
                    send_item(seq[i]);
                tests_run++;
                if (tests_run % 12 == 0)
                    wait_for_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence. The result side's ready is owned by the checking
    // process, which sets it from the first clock edge on.
    // ------------------------------------------------------------------
    initial
    begin
        vec_ch.valid     <= 1'b0;
        vec_ch.item_kind <= sait_pkg::KIND_AXIS;
        vec_ch.coord_x   <= '0;
        vec_ch.coord_y   <= '0;
        vec_ch.coord_z   <= '0;
        vec_ch.last_item <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_centres_at_reset();
        test_extreme_values();
        test_held_centres();
        test_empty_sets();
        test_ignored_kinds();
        test_axis_closes_test();
        test_zero_axis();
        wait_for_results();
        test_random_tests();

        // Let the last verdicts drain, then allow for any stray result transaction.
        vec_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d vector transactions; checked %0d verdicts, %0d separated and",
                 vectors_sent, closed_tests, separated_tests);
        $display("%0d with an empty vertex set, under random idling and at full rate.",
                 empty_tests);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
